// ----- rtl/wrng_pkg.sv -----
// ============================================================================
// wrng_pkg
// Shared types and constants of the weighted random note gate.
// ============================================================================
package wrng_pkg;

   // fixed field widths
   localparam int CH_W     = 4;
   localparam int FRAC_W   = 16;
   localparam int NOTE_W   = 4;
   localparam int WEIGHT_W = 7;
   localparam int REG_W    = 56;
   localparam int SUM_W    = 11;   // holds 16 * 127
   localparam int PROD_W   = FRAC_W + SUM_W;
   localparam int NOTES_PER_REG = 8;

   // parameter defaults
   localparam int DEF_NUM_CHANNELS = 16;
   localparam int DEF_NUM_NOTES    = 16;
   localparam int DEF_WEIGHT_MAX   = 100;

   // packed widths on the stream ports
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   // register indexes
   localparam logic [1:0] CSR_WEIGHTS_LOW  = 2'd0;
   localparam logic [1:0] CSR_WEIGHTS_HIGH = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_HOLD  = 2'd2;

   typedef logic [SUM_W-1:0] sum_type;

   // one channel's stored state
   typedef struct packed {
      logic [NOTE_W-1:0] last_note;
      logic [NOTE_W-1:0] output_note;
   } state_entry_type;

   // write port into the state memory
   typedef struct packed {
      logic              en;
      logic [CH_W-1:0]   addr;
      state_entry_type   data;
   } mem_wr_type;

endpackage

// ----- rtl/weighted_random_note_gate_top.sv -----
// A taken request passes through the stage 1 and stage 2 registers into the output register.
// Throughput: one transaction per cycle; the state memory read-modify-write with a
// same-edge bypass sets that figure, and the pipeline advances only when the output
// register is free or being emptied. Reset is synchronous: config to defaults, and
// per-channel valid bits cleared at once, so every channel's state reads as zero.
// ============================================================================
// weighted_random_note_gate_top
// Weighted note choice, random gate and trigger per clock channel.
// ============================================================================
module weighted_random_note_gate_top #(
   parameter int NUM_CHANNELS = wrng_pkg::DEF_NUM_CHANNELS,
   parameter int NUM_NOTES    = wrng_pkg::DEF_NUM_NOTES,
   parameter int WEIGHT_MAX   = wrng_pkg::DEF_WEIGHT_MAX
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // channel[3:0], random_coin[19:4], random_pick[35:20], rest_chance[51:36]
   input  logic [wrng_pkg::REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_channel[3:0], gate_on[4], chosen_note[8:5], held_note[12:9], trigger[13]
   output logic [wrng_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [wrng_pkg::REG_W-1:0]     csr_wdata
);
   import wrng_pkg::*;

   // input fields
   logic [CH_W-1:0]   req_channel;
   logic [FRAC_W-1:0] req_coin;
   logic [FRAC_W-1:0] req_pick;
   logic [FRAC_W-1:0] req_rest;

   assign req_channel = req_tdata[3:0];
   assign req_coin    = req_tdata[19:4];
   assign req_pick    = req_tdata[35:20];
   assign req_rest    = req_tdata[51:36];

   sum_type         prefix [NUM_NOTES];
   logic            sample_hold;
   logic            advance;
   mem_wr_type      mem_wr;
   state_entry_type mem_rd;

   // stage 1 registers
   logic              s1_valid_ff;
   logic [CH_W-1:0]   s1_channel_ff;
   logic              s1_in_range_ff;
   logic              s1_gate_ff;
   logic [FRAC_W-1:0] s1_pick_ff;
   sum_type           s1_prefix_ff [NUM_NOTES];

   // stage 2 registers
   logic              s2_valid_ff;
   logic [CH_W-1:0]   s2_channel_ff;
   logic              s2_in_range_ff;
   logic              s2_gate_ff;
   sum_type           s2_idx_ff;
   logic              s2_small_ff;
   sum_type           s2_prefix_ff [NUM_NOTES];

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [PROD_W-1:0] s1_prod;
   sum_type           s1_total;
   logic [NOTE_W-1:0] s2_note;
   logic              s2_changed;
   logic              s2_trigger;
   logic [NOTE_W-1:0] s2_held;

   wrng_csr #(
      .NUM_NOTES  (NUM_NOTES),
      .WEIGHT_MAX (WEIGHT_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .prefix      (prefix),
      .sample_hold (sample_hold)
   );

   wrng_state_mem #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (s1_channel_ff),
      .wr      (mem_wr),
      .rd_data (mem_rd)
   );

   // whole pipeline moves when the output register can take a result
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage 1: capture transaction, gate decision and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_channel_ff  <= req_channel;
         s1_in_range_ff <= ({1'b0, req_channel} < (CH_W+1)'(NUM_CHANNELS));
         s1_gate_ff     <= (req_coin < req_rest);
         s1_pick_ff     <= req_pick;
         for (int k = 0; k < NUM_NOTES; k++) begin
            s1_prefix_ff[k] <= prefix[k];
         end
      end
   end

   // stage 1 -> 2: scale the pick fraction by the weight total
   assign s1_total = s1_prefix_ff[NUM_NOTES-1];
   assign s1_prod  = PROD_W'(s1_pick_ff) * PROD_W'(s1_total);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_channel_ff  <= s1_channel_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_gate_ff     <= s1_gate_ff;
         s2_idx_ff      <= s1_prod[PROD_W-1:FRAC_W];
         s2_small_ff    <= (s1_total < SUM_W'(2));
         for (int k = 0; k < NUM_NOTES; k++) begin
            s2_prefix_ff[k] <= s1_prefix_ff[k];
         end
      end
   end

   // stage 2: first note whose running sum exceeds the index, or note 0 if the total is below 2
   always_comb begin
      s2_note = '0;
      if (!s2_small_ff) begin
         for (int k = NUM_NOTES - 1; k >= 0; k--) begin
            if (s2_prefix_ff[k] > s2_idx_ff) begin
               s2_note = NOTE_W'(k);
            end
         end
      end
   end

   // stage 2: channel state update and result
   always_comb begin
      s2_changed = (s2_note != mem_rd.last_note);
      s2_trigger = s2_gate_ff && s2_changed;
      if (sample_hold && !s2_gate_ff) begin
         s2_held = mem_rd.output_note;
      end else begin
         s2_held = s2_note;
      end

      mem_wr.en                    = advance && s2_valid_ff && s2_in_range_ff;
      mem_wr.addr                  = s2_channel_ff;
      mem_wr.data.last_note        = s2_note;
      mem_wr.data.output_note      = s2_held;

      rsp_data_in        = '0;
      rsp_data_in[3:0]   = s2_channel_ff;
      rsp_data_in[8:5]   = s2_note;
      if (s2_in_range_ff) begin
         rsp_data_in[4]    = s2_gate_ff;
         rsp_data_in[12:9] = s2_held;
         rsp_data_in[13]   = s2_trigger;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/wrng_csr.sv -----
// ============================================================================
// wrng_csr
// Configuration registers, weight saturation and running weight sums.
// ============================================================================
module wrng_csr #(
   parameter int NUM_NOTES  = wrng_pkg::DEF_NUM_NOTES,
   parameter int WEIGHT_MAX = wrng_pkg::DEF_WEIGHT_MAX
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [wrng_pkg::REG_W-1:0] csr_wdata,
   output wrng_pkg::sum_type         prefix [NUM_NOTES],
   output logic                      sample_hold
);
   import wrng_pkg::*;

   localparam int LEVELS = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;

   logic [REG_W-1:0] weights_low_ff;
   logic [REG_W-1:0] weights_high_ff;
   logic             sample_hold_ff;
   sum_type          scan [LEVELS+1][NUM_NOTES];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weights_low_ff  <= '0;
         weights_high_ff <= '0;
         sample_hold_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WEIGHTS_LOW:  weights_low_ff  <= csr_wdata;
            CSR_WEIGHTS_HIGH: weights_high_ff <= csr_wdata;
            CSR_SAMPLE_HOLD:  sample_hold_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturated weights, then a log-depth prefix scan
   always_comb begin
      logic [WEIGHT_W-1:0] fld;
      fld = '0;
      for (int k = 0; k < NUM_NOTES; k++) begin
         if (k < NOTES_PER_REG) begin
            fld = weights_low_ff[k*WEIGHT_W +: WEIGHT_W];
         end else begin
            fld = weights_high_ff[(k-NOTES_PER_REG)*WEIGHT_W +: WEIGHT_W];
         end
         if (fld > WEIGHT_W'(WEIGHT_MAX)) begin
            fld = WEIGHT_W'(WEIGHT_MAX);
         end
         scan[0][k] = SUM_W'(fld);
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int k = 0; k < NUM_NOTES; k++) begin
            if (k >= (1 << l)) begin
               scan[l+1][k] = scan[l][k] + scan[l][k-(1<<l)];
            end else begin
               scan[l+1][k] = scan[l][k];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_NOTES; k++) begin
         prefix[k] = scan[LEVELS][k];
      end
   end

   assign sample_hold = sample_hold_ff;

endmodule

// ----- rtl/wrng_state_mem.sv -----
// ============================================================================
// wrng_state_mem
// Per-channel note state: synchronous memory with valid bits and a
// write-to-read bypass for back-to-back accesses to one channel.
// ============================================================================
module wrng_state_mem #(
   parameter int NUM_CHANNELS = wrng_pkg::DEF_NUM_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [wrng_pkg::CH_W-1:0]  rd_addr,
   input  wrng_pkg::mem_wr_type       wr,
   output wrng_pkg::state_entry_type  rd_data
);
   import wrng_pkg::*;

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   state_entry_type mem [NUM_CHANNELS];
   logic            valid_ff [NUM_CHANNELS];
   state_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         valid_ff[wr.addr[AW-1:0]] <= 1'b1;
      end
   end

   // registered read, bypassing a write to the same entry on this edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else if (valid_ff[rd_addr[AW-1:0]]) begin
            rd_data_ff <= mem[rd_addr[AW-1:0]];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
